/* src/trd_pkg.sv */
// Shared types and constants for the TLS 1.3 record deframer.
`default_nettype none
package trd_pkg;

  localparam int unsigned MAX_RECORD_DEF = 16640;
  localparam int unsigned LEN_W          = 15;
  localparam int unsigned HEAD_W         = 32;
  localparam int unsigned TAIL_W         = 64;
  localparam int unsigned CFG_W          = 64;

  localparam logic [7:0] TYPE_CCS  = 8'h14;
  localparam logic [7:0] TYPE_APP  = 8'h17;
  localparam int unsigned TAG_BYTES = 16;

  // input item kinds
  localparam logic KIND_BYTE     = 1'b0;
  localparam logic KIND_NEW_KEYS = 1'b1;

  // configuration register indexes
  localparam logic CFG_IV_HEAD = 1'b0;
  localparam logic CFG_IV_TAIL = 1'b1;

  typedef enum logic [1:0] {
    RK_START = 2'd0,
    RK_BODY  = 2'd1,
    RK_ERROR = 2'd2
  } result_kind_t;

  typedef enum logic [1:0] {
    ERR_NONE   = 2'd0,
    ERR_LENGTH = 2'd1,
    ERR_TYPE   = 2'd2,
    ERR_SHORT  = 2'd3
  } error_t;

  typedef struct packed {
    result_kind_t      kind;
    logic [HEAD_W-1:0] nonce_head;
    logic [TAIL_W-1:0] nonce_tail;
    logic [LEN_W-1:0]  record_length;
    logic [7:0]        body_byte;
    logic              in_tag;
    logic              last;
    error_t            error_code;
  } result_t;

endpackage
`default_nettype wire

/* src/tls13_record_deframer_core.sv */
// Top level of the TLS 1.3 record deframer: input stage, parser, result register.
//
//  channel | dir | ports                                   | handshake
//  --------+-----+-----------------------------------------+-----------------
//  in      | in  | in_kind, in_data_byte                   | in_valid/in_ready
//  out     | out | out_result_kind .. out_error_code       | out_valid/out_ready
//  cfg     | in  | cfg_index, cfg_wdata                    | cfg_we, no wait
//
// One byte per cycle sustained while out_ready stays high; an item waits in the input
// register and its result (if any) is loaded into the result register as it leaves.
// Synchronous active-low reset clears the parser state, IV and both stages.
// A stalled output holds the result; the input stage keeps taking bytes until
// it is also full, then in_ready drops.
`default_nettype none
module tls13_record_deframer_core #(
  parameter int unsigned MAX_RECORD = trd_pkg::MAX_RECORD_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_kind,
  input  logic [7:0]                  in_data_byte,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  out_result_kind,
  output logic [trd_pkg::HEAD_W-1:0]  out_nonce_head,
  output logic [trd_pkg::TAIL_W-1:0]  out_nonce_tail,
  output logic [trd_pkg::LEN_W-1:0]   out_record_length,
  output logic [7:0]                  out_body_byte,
  output logic                        out_in_tag,
  output logic                        out_last,
  output logic [1:0]                  out_error_code,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [trd_pkg::CFG_W-1:0]   cfg_wdata
);
  import trd_pkg::*;

  logic [HEAD_W-1:0] iv_head_r;
  logic [TAIL_W-1:0] iv_tail_r;

  logic       s1_valid_r, s1_valid_nxt;
  logic       s1_kind_r;
  logic [7:0] s1_byte_r;
  logic       s1_adv;
  logic       in_xfer;

  logic       res_valid;
  result_t    res;
  logic       out_valid_r, out_valid_nxt;
  result_t    out_res_r;

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iv_head_r <= '0;
      iv_tail_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IV_HEAD: iv_head_r <= cfg_wdata[HEAD_W-1:0];
        CFG_IV_TAIL: iv_tail_r <= cfg_wdata[TAIL_W-1:0];
        default: ;
      endcase
    end
  end

  // input stage
  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_xfer  = in_valid && in_ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_xfer) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_kind_r <= in_kind;
      s1_byte_r <= in_data_byte;
    end
  end

  trd_parse #(
    .MAX_RECORD (MAX_RECORD)
  ) u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (s1_adv),
    .item_kind (s1_kind_r),
    .item_byte (s1_byte_r),
    .iv_head   (iv_head_r),
    .iv_tail   (iv_tail_r),
    .res_valid (res_valid),
    .res       (res)
  );

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = res_valid;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_result_kind   = out_res_r.kind;
  assign out_nonce_head    = out_res_r.nonce_head;
  assign out_nonce_tail    = out_res_r.nonce_tail;
  assign out_record_length = out_res_r.record_length;
  assign out_body_byte     = out_res_r.body_byte;
  assign out_in_tag        = out_res_r.in_tag;
  assign out_last          = out_res_r.last;
  assign out_error_code    = out_res_r.error_code;

  // an empty result register never blocks the input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ready)
    else $error("input stalled with empty result register");

  // error results always carry a code
  a_error_has_code: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.kind == RK_ERROR) |-> (out_res_r.error_code != ERR_NONE))
    else $error("error result without code");

  // records are at least one tag long, so the last byte is a tag byte
  a_last_in_tag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.kind == RK_BODY && out_res_r.last) |-> out_res_r.in_tag)
    else $error("last body byte outside tag");

  // new keys never produce a result
  a_new_keys_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_kind_r == KIND_NEW_KEYS) |-> !res_valid)
    else $error("new keys produced a result");

endmodule
`default_nettype wire

/* src/trd_parse.sv */
// Record header parser, body tracker and sequence counter.
`default_nettype none
module trd_parse #(
  parameter int unsigned MAX_RECORD = trd_pkg::MAX_RECORD_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      step,
  input  logic                      item_kind,
  input  logic [7:0]                item_byte,
  input  logic [trd_pkg::HEAD_W-1:0] iv_head,
  input  logic [trd_pkg::TAIL_W-1:0] iv_tail,
  output logic                      res_valid,
  output trd_pkg::result_t          res
);
  import trd_pkg::*;

  localparam int unsigned REM_W = $clog2(MAX_RECORD + 1);

  localparam logic [2:0] HDR_TYPE  = 3'd0;
  localparam logic [2:0] HDR_VER0  = 3'd1;
  localparam logic [2:0] HDR_VER1  = 3'd2;
  localparam logic [2:0] HDR_LENHI = 3'd3;

  logic [2:0]        hdr_pos_r,  hdr_pos_nxt;
  logic [7:0]        type_r,     type_nxt;
  logic [7:0]        len_hi_r,   len_hi_nxt;
  logic [REM_W-1:0]  rem_r,      rem_nxt;
  logic              drop_r,     drop_nxt;
  logic [TAIL_W-1:0] seq_r,      seq_nxt;
  logic              failed_r,   failed_nxt;

  logic [15:0] len16;

  assign len16 = {len_hi_r, item_byte};

  always_comb begin
    hdr_pos_nxt = hdr_pos_r;
    type_nxt    = type_r;
    len_hi_nxt  = len_hi_r;
    rem_nxt     = rem_r;
    drop_nxt    = drop_r;
    seq_nxt     = seq_r;
    failed_nxt  = failed_r;
    res_valid   = 1'b0;
    res         = '0;

    if (item_kind == KIND_NEW_KEYS) begin
      seq_nxt     = '0;
      hdr_pos_nxt = HDR_TYPE;
      rem_nxt     = '0;
      drop_nxt    = 1'b0;
      failed_nxt  = 1'b0;
    end else if (failed_r) begin
      // sticky: bytes are swallowed until new keys
    end else if (rem_r != '0) begin
      rem_nxt = rem_r - REM_W'(1);
      if (drop_r) begin
        if (rem_r == REM_W'(1)) begin
          drop_nxt = 1'b0;
        end
      end else begin
        res_valid     = 1'b1;
        res.kind      = RK_BODY;
        res.body_byte = item_byte;
        res.in_tag    = (rem_r <= REM_W'(TAG_BYTES));
        res.last      = (rem_r == REM_W'(1));
      end
    end else begin
      case (hdr_pos_r) inside
        HDR_TYPE: begin
          type_nxt    = item_byte;
          hdr_pos_nxt = HDR_VER0;
        end
        HDR_VER0, HDR_VER1: begin
          hdr_pos_nxt = hdr_pos_r + 3'd1;
        end
        HDR_LENHI: begin
          len_hi_nxt  = item_byte;
          hdr_pos_nxt = hdr_pos_r + 3'd1;
        end
        default: begin
          // low length byte completes the header
          hdr_pos_nxt = HDR_TYPE;
          if (len16 > 16'(MAX_RECORD)) begin
            failed_nxt     = 1'b1;
            res_valid      = 1'b1;
            res.kind       = RK_ERROR;
            res.error_code = ERR_LENGTH;
          end else begin
            rem_nxt  = len16[REM_W-1:0];
            drop_nxt = (len16 != 16'd0);
            if (type_r == TYPE_CCS) begin
              // silently consumed
            end else if (type_r != TYPE_APP) begin
              res_valid      = 1'b1;
              res.kind       = RK_ERROR;
              res.error_code = ERR_TYPE;
            end else if (len16 < 16'(TAG_BYTES)) begin
              seq_nxt        = seq_r + TAIL_W'(1);
              res_valid      = 1'b1;
              res.kind       = RK_ERROR;
              res.error_code = ERR_SHORT;
            end else begin
              drop_nxt          = 1'b0;
              seq_nxt           = seq_r + TAIL_W'(1);
              res_valid         = 1'b1;
              res.kind          = RK_START;
              res.nonce_head    = iv_head;
              res.nonce_tail    = iv_tail ^ seq_r;
              res.record_length = len16[LEN_W-1:0];
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_pos_r <= HDR_TYPE;
      type_r    <= '0;
      len_hi_r  <= '0;
      rem_r     <= '0;
      drop_r    <= 1'b0;
      seq_r     <= '0;
      failed_r  <= 1'b0;
    end else if (step) begin
      hdr_pos_r <= hdr_pos_nxt;
      type_r    <= type_nxt;
      len_hi_r  <= len_hi_nxt;
      rem_r     <= rem_nxt;
      drop_r    <= drop_nxt;
      seq_r     <= seq_nxt;
      failed_r  <= failed_nxt;
    end
  end

  // header counter never passes the low length byte
  a_hdr_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    hdr_pos_r <= 3'd4)
    else $error("header position out of range");

  // no body is in flight while parsing is stuck
  a_failed_no_body: assert property (@(posedge clk) disable iff (!rst_n)
    failed_r |-> (rem_r == '0))
    else $error("body pending with sticky error");

  // a drop in progress always has bytes left
  a_drop_rem: assert property (@(posedge clk) disable iff (!rst_n)
    drop_r |-> (rem_r != '0))
    else $error("drop flag without remaining bytes");

endmodule
`default_nettype wire
